/* rtl/rlw_pkg.sv */
// Shared types and constants for the referee link watchdog.
`default_nettype none
package rlw_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_FRAME   = 2'd1;
  localparam logic [1:0] CMD_CONSUME = 2'd2;
  localparam logic [1:0] CMD_DISCARD = 2'd3;

  localparam logic [1:0] PH_OFFLINE = 2'd0;
  localparam logic [1:0] PH_WARMUP  = 2'd1;
  localparam logic [1:0] PH_ARMED   = 2'd2;

  localparam logic [1:0] CFG_OFFLINE_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_WARMUP_FRAMES   = 2'd1;
  localparam logic [1:0] CFG_WARMUP_TIME     = 2'd2;

  localparam logic [15:0] OFFLINE_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  WARMUP_FRAMES_RST   = 8'd3;
  localparam logic [15:0] WARMUP_TIME_RST     = 16'd500;
  localparam logic [7:0]  COUNT_MAX           = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [63:0] frame_low;
    logic [39:0] frame_high;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  link_status;
    logic        fresh;
    logic        hit_event;
    logic [3:0]  team_color;
    logic [3:0]  match_stage;
    logic [15:0] hit_points;
    logic [15:0] power_limit;
    logic [15:0] power_buffer;
    logic [15:0] barrel_heat;
    logic [7:0]  launch_rate;
    logic [15:0] speed_centi;
    logic [7:0]  hurt_info;
  } out_word_t;

endpackage
`default_nettype wire

/* rtl/referee_link_watchdog.sv */
// Top level of the referee link watchdog: input register, update core, result register.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command word (tick,
//   frame, consume, discard) with the current millisecond time and, for a
//   frame, the 13 status bytes. Every accepted word yields exactly one result
//   word on out_valid/out_stall/out_data: link phase, fresh flag, hit pulse
//   and the fields of the last decoded frame.
//   Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high and an index above two is ignored.
//   A word accepted into the input register passes through the update core
//   into the result register, which drives out_data.
//   Throughput: one word per cycle while out_stall is low, set by the single
//   update step between the input register and the result register.
//   Reset (rst_n low at a clock edge) empties both registers, restores the
//   register defaults and puts the link offline with a zero frame.
//   While out_stall holds a result, the input register keeps its word and
//   in_stall rises once it is full; no word is lost or repeated.
`default_nettype none
module referee_link_watchdog (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output wire logic           in_stall,
  input  rlw_pkg::in_word_t   in_data,
  output wire logic           out_valid,
  input  wire logic           out_stall,
  output rlw_pkg::out_word_t  out_data,
  input  wire logic           cfg_valid,
  output wire logic           cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  import rlw_pkg::*;

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  out_word_t core_word;
  logic      advance;

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  rlw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_vld_r && advance),
    .word_in   (in_word_r),
    .word_out  (core_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_data;
    end
    if (advance && in_vld_r) begin
      out_word_r <= core_word;
    end
  end

endmodule
`default_nettype wire

/* rtl/rlw_core.sv */
// Link state, configuration registers and the per-word update logic.
`default_nettype none
module rlw_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             step,
  input  rlw_pkg::in_word_t     word_in,
  output rlw_pkg::out_word_t    word_out
);
  import rlw_pkg::*;

  logic [15:0] timeout_r;
  logic [7:0]  wframes_r;
  logic [15:0] wtime_r;

  logic [1:0]  phase_r,      phase_nxt;
  logic [31:0] last_r,       last_nxt;
  logic [31:0] start_r,      start_nxt;
  logic [7:0]  count_r,      count_nxt;
  logic        online_r,     online_nxt;
  logic        fresh_r,      fresh_nxt;
  logic        pulse_r,      pulse_nxt;
  logic [15:0] base_r,       base_nxt;
  logic [63:0] flo_r,        flo_nxt;
  logic [39:0] fhi_r,        fhi_nxt;
  logic        hit_out;

  logic [31:0] since_last;
  logic [31:0] since_start;
  logic [7:0]  count_inc;
  logic [15:0] hp_new;
  logic [3:0]  reason_new;
  logic        timed_out;

  assign since_last  = word_in.now_ms - last_r;
  assign since_start = word_in.now_ms - start_r;
  assign count_inc   = (count_r < COUNT_MAX) ? count_r + 8'd1 : count_r;
  assign hp_new      = word_in.frame_low[23:8];
  assign reason_new  = word_in.frame_high[39:36];
  assign timed_out   = online_r && (last_r != 32'd0) && (since_last > {16'd0, timeout_r});

  always_comb begin
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    online_nxt = online_r;
    fresh_nxt  = fresh_r;
    pulse_nxt  = pulse_r;
    base_nxt   = base_r;
    flo_nxt    = flo_r;
    fhi_nxt    = fhi_r;
    hit_out    = pulse_r;
    unique case (word_in.cmd)
      CMD_TICK: begin
        fresh_nxt = 1'b0;
        if (timed_out) begin
          phase_nxt  = PH_OFFLINE;
          last_nxt   = 32'd0;
          start_nxt  = 32'd0;
          count_nxt  = 8'd0;
          online_nxt = 1'b0;
          pulse_nxt  = 1'b0;
          base_nxt   = flo_r[23:8];
        end
        hit_out = pulse_nxt;
      end
      CMD_FRAME: begin
        flo_nxt    = word_in.frame_low;
        fhi_nxt    = word_in.frame_high;
        last_nxt   = word_in.now_ms;
        online_nxt = 1'b1;
        fresh_nxt  = 1'b1;
        pulse_nxt  = 1'b0;
        base_nxt   = hp_new;
        priority case (phase_r)
          PH_OFFLINE: begin
            phase_nxt = PH_WARMUP;
            start_nxt = word_in.now_ms;
            count_nxt = 8'd1;
          end
          PH_WARMUP: begin
            count_nxt = count_inc;
            if (count_inc >= wframes_r && since_start >= {16'd0, wtime_r}) begin
              phase_nxt = PH_ARMED;
            end
          end
          default: begin
            pulse_nxt = (hp_new < base_r) && (reason_new == 4'd0);
          end
        endcase
        hit_out = pulse_nxt;
      end
      CMD_CONSUME: begin
        hit_out   = pulse_r;
        pulse_nxt = 1'b0;
      end
      CMD_DISCARD: begin
        hit_out   = 1'b0;
        pulse_nxt = 1'b0;
      end
      default: begin
        hit_out = pulse_r;
      end
    endcase
  end

  always_comb begin
    word_out.link_status  = phase_nxt;
    word_out.fresh        = fresh_nxt;
    word_out.hit_event    = hit_out;
    word_out.team_color   = flo_nxt[7:4];
    word_out.match_stage  = flo_nxt[3:0];
    word_out.hit_points   = flo_nxt[23:8];
    word_out.power_limit  = flo_nxt[39:24];
    word_out.power_buffer = flo_nxt[55:40];
    word_out.barrel_heat  = {fhi_nxt[7:0], flo_nxt[63:56]};
    word_out.launch_rate  = fhi_nxt[15:8];
    word_out.speed_centi  = fhi_nxt[31:16];
    word_out.hurt_info    = fhi_nxt[39:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= OFFLINE_TIMEOUT_RST;
      wframes_r <= WARMUP_FRAMES_RST;
      wtime_r   <= WARMUP_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFLINE_TIMEOUT: timeout_r <= cfg_data;
        CFG_WARMUP_FRAMES:   wframes_r <= cfg_data[7:0];
        CFG_WARMUP_TIME:     wtime_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OFFLINE;
      last_r   <= 32'd0;
      start_r  <= 32'd0;
      count_r  <= 8'd0;
      online_r <= 1'b0;
      fresh_r  <= 1'b0;
      pulse_r  <= 1'b0;
      base_r   <= 16'd0;
      flo_r    <= 64'd0;
      fhi_r    <= 40'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      last_r   <= last_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      online_r <= online_nxt;
      fresh_r  <= fresh_nxt;
      pulse_r  <= pulse_nxt;
      base_r   <= base_nxt;
      flo_r    <= flo_nxt;
      fhi_r    <= fhi_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/rlw_chk.sv */
// Port-level checks for the referee link watchdog, bound to the top level.
`default_nettype none
module rlw_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input rlw_pkg::out_word_t  out_data
);
  import rlw_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_offline_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.link_status == PH_OFFLINE |-> !out_data.fresh && !out_data.hit_event)
    else $error("offline result shows fresh or hit");

  a_warmup_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.link_status == PH_WARMUP |-> !out_data.hit_event)
    else $error("hit pulse during warmup");

endmodule

bind referee_link_watchdog rlw_chk u_rlw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
